/* hw/rtl/motion_window_activity_detector_macros.svh */
// Assertion helpers for the activity detector.
// MWAD_ASSERT checks a property that is ignored while reset is high;
// MWAD_ASSERT_ALWAYS checks it on every clock edge, reset included.
`ifndef MOTION_WINDOW_ACTIVITY_DETECTOR_MACROS_SVH
`define MOTION_WINDOW_ACTIVITY_DETECTOR_MACROS_SVH
`ifndef SYNTHESIS
`define MWAD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mwad assertion failed");
`define MWAD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mwad assertion failed");
`else
`define MWAD_ASSERT(label, clk, rst, prop)
`define MWAD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hw/rtl/mwad_pkg.sv */
`default_nettype none

package mwad_pkg;

  // Window length default and field widths
  localparam int WINDOW_DEFAULT = 35;
  localparam int AXIS_W         = 16;
  localparam int MAG_W          = 32;
  localparam int COUNT_W        = 7;
  localparam int S_DATA_W       = 48;
  localparam int M_DATA_W       = 16;

  // Configuration port
  localparam int REG_ADDR_W = 4;
  localparam int REG_DATA_W = 32;
  localparam logic [1:0] REG_LOW_LIMIT       = 2'd0;
  localparam logic [1:0] REG_HIGH_LIMIT      = 2'd1;
  localparam logic [1:0] REG_COUNT_THRESHOLD = 2'd2;

  // Register reset values: band of 0.975 g to 1.025 g at 256 LSB per g
  localparam logic [MAG_W-1:0]   LOW_LIMIT_RESET  = 32'd62301;
  localparam logic [MAG_W-1:0]   HIGH_LIMIT_RESET = 32'd68853;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET  = 7'd7;

  typedef struct packed {
    logic [MAG_W-1:0]   low_limit_sq;
    logic [MAG_W-1:0]   high_limit_sq;
    logic [COUNT_W-1:0] count_threshold;
  } cfg_t;

  typedef struct packed {
    logic [MAG_W-1:0] xx;
    logic [MAG_W-1:0] yy;
    logic [MAG_W-1:0] zz;
  } sq_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] fill;
  } win_status_t;

endpackage

`default_nettype wire

/* hw/rtl/mwad_regs.sv */
`default_nettype none

module mwad_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mwad_pkg::REG_ADDR_W-1:0]  paddr,
  input  wire logic [mwad_pkg::REG_DATA_W-1:0]  pwdata,
  output logic      [mwad_pkg::REG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output mwad_pkg::cfg_t                        cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write registers; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit_sq    <= mwad_pkg::LOW_LIMIT_RESET;
      cfg.high_limit_sq   <= mwad_pkg::HIGH_LIMIT_RESET;
      cfg.count_threshold <= mwad_pkg::THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        mwad_pkg::REG_LOW_LIMIT:       cfg.low_limit_sq    <= pwdata;
        mwad_pkg::REG_HIGH_LIMIT:      cfg.high_limit_sq   <= pwdata;
        mwad_pkg::REG_COUNT_THRESHOLD: begin
          cfg.count_threshold <= pwdata[mwad_pkg::COUNT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      mwad_pkg::REG_LOW_LIMIT:       prdata = cfg.low_limit_sq;
      mwad_pkg::REG_HIGH_LIMIT:      prdata = cfg.high_limit_sq;
      mwad_pkg::REG_COUNT_THRESHOLD: prdata = mwad_pkg::REG_DATA_W'(cfg.count_threshold);
      default:                       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/mwad_square.sv */
`default_nettype none

module mwad_square (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mwad_pkg::S_DATA_W-1:0]  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mwad_pkg::sq_t                       out_sq
);

  localparam int AW = mwad_pkg::AXIS_W;

  // Input register stage
  logic                 a_valid;
  logic                 a_ready;
  logic signed [AW-1:0] a_x;
  logic signed [AW-1:0] a_y;
  logic signed [AW-1:0] a_z;

  logic signed [mwad_pkg::MAG_W-1:0] xx;
  logic signed [mwad_pkg::MAG_W-1:0] yy;
  logic signed [mwad_pkg::MAG_W-1:0] zz;

  assign a_ready  = !a_valid || out_ready || !out_valid;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_x <= in_data[AW-1:0];
      a_y <= in_data[2*AW-1:AW];
      a_z <= in_data[3*AW-1:2*AW];
    end
  end

  // Square each axis; results are non-negative and fit 32 bits
  assign xx = a_x * a_x;
  assign yy = a_y * a_y;
  assign zz = a_z * a_z;

  // Product register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && (!out_valid || out_ready)) begin
      out_sq.xx <= $unsigned(xx);
      out_sq.yy <= $unsigned(yy);
      out_sq.zz <= $unsigned(zz);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mwad_window.sv */
`default_nettype none

module mwad_window #(
  parameter int WINDOW = mwad_pkg::WINDOW_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mwad_pkg::cfg_t                 cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mwad_pkg::sq_t                  in_sq,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mwad_pkg::M_DATA_W-1:0]       out_data,
  output mwad_pkg::win_status_t               status
);

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int CW     = mwad_pkg::COUNT_W;

  logic [WINDOW-1:0]          marks;
  logic [WINDOW-1:0]          marks_next;
  logic [FILL_W-1:0]          fill;
  logic [FILL_W-1:0]          fill_next;
  logic [FILL_W-1:0]          count;
  logic [FILL_W-1:0]          count_next;
  logic [mwad_pkg::MAG_W-1:0] mag;
  logic                       moving;
  logic                       full;
  logic                       drop;
  logic                       take;
  logic                       detect_next;
  logic                       res_moving;
  logic [CW-1:0]              res_count;
  logic                       res_detect;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Squared magnitude against the band
  assign mag    = in_sq.xx + in_sq.yy + in_sq.zz;
  assign moving = (mag < cfg.low_limit_sq) || (mag > cfg.high_limit_sq);

  // Shift the new mark in; the oldest leaves once the window is full
  always_comb begin
    full        = (fill == FILL_W'(WINDOW));
    drop        = full && marks[WINDOW-1];
    marks_next  = WINDOW'({marks, moving});
    fill_next   = full ? fill : fill + FILL_W'(1);
    count_next  = count - FILL_W'(drop) + FILL_W'(moving);
    detect_next = CW'(count_next) > cfg.count_threshold;
  end

  // Window state
  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
      fill  <= '0;
      count <= '0;
    end else if (take) begin
      marks <= marks_next;
      fill  <= fill_next;
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_moving <= moving;
      res_count  <= CW'(count_next);
      res_detect <= detect_next;
    end
  end

  assign out_data = mwad_pkg::M_DATA_W'({res_detect, res_count, res_moving});

  assign status.count = CW'(count);
  assign status.fill  = CW'(fill);

endmodule

`default_nettype wire

/* hw/rtl/motion_window_activity_detector.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: accel_x, accel_y, accel_z
// m_*       out  m_tvalid/m_tready  m_tdata: sample_moving, moving_count, detected
// apb       in   psel/penable       low_limit_sq, high_limit_sq, count_threshold
//
// Up to one sample per cycle while m_tready holds high; each result word
// passes through the input register, square register and result register.
// The window count update feeds the count register back through combinational logic.
// Reset clears all stage valids, the window marks, fill level and count, and
// loads the register defaults. A stall on m_tready backs up stage by stage;
// s_tready drops only when all three stages hold a word.
`default_nettype none
`include "motion_window_activity_detector_macros.svh"

module motion_window_activity_detector #(
  parameter int WINDOW = mwad_pkg::WINDOW_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
  input  wire logic [mwad_pkg::S_DATA_W-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [0] sample_moving, [7:1] moving_count, [8] detected, [15:9] zero
  output logic      [mwad_pkg::M_DATA_W-1:0]    m_tdata,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mwad_pkg::REG_ADDR_W-1:0]  paddr,
  input  wire logic [mwad_pkg::REG_DATA_W-1:0]  pwdata,
  output logic      [mwad_pkg::REG_DATA_W-1:0]  prdata,
  output logic                                  pready
);

  mwad_pkg::cfg_t        cfg;
  mwad_pkg::sq_t         sq;
  mwad_pkg::win_status_t status;
  logic                  sq_valid;
  logic                  sq_ready;

  mwad_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mwad_square u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_sq    (sq)
  );

  mwad_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_sq     (sq),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .status    (status)
  );

  // Checks
  `MWAD_ASSERT(a_count_le_fill, clk, rst, status.count <= status.fill)
  `MWAD_ASSERT(a_fill_le_window, clk, rst, status.fill <= mwad_pkg::COUNT_W'(WINDOW))
  `MWAD_ASSERT(a_stall_from_out, clk, rst, !s_tready |-> (m_tvalid && !m_tready))
  `MWAD_ASSERT_ALWAYS(a_empty_after_reset, clk, $past(rst) |-> !m_tvalid)

endmodule

`default_nettype wire
